>>> design/lcdseq_pkg.sv
// Package for the character LCD nibble write sequencer.
// Holds the command codes, the micro-op layout and the microcode program.
// No dependencies.
`default_nettype none

package lcdseq_pkg;

	localparam int NIBBLE_W = 4;
	localparam int BYTE_W   = 8;
	localparam int WAIT_W   = 16;
	localparam int PC_W     = 5;

	localparam logic [WAIT_W-1:0] INSTR_WAIT_RESET = 16'd1000;
	localparam logic [WAIT_W-1:0] WAIT_1MS_US      = 16'd1000;
	localparam logic [WAIT_W-1:0] WAIT_10MS_US     = 16'd10000;
	localparam logic [WAIT_W-1:0] WAIT_50MS_US     = 16'd50000;

	// Instruction bytes used by the commands.
	localparam logic [BYTE_W-1:0] INSTR_FUNC_SET   = 8'b0010_1000;
	localparam logic [BYTE_W-1:0] INSTR_DISP_OFF   = 8'b0000_1000;
	localparam logic [BYTE_W-1:0] INSTR_CLEAR      = 8'b0000_0001;
	localparam logic [BYTE_W-1:0] INSTR_ENTRY_MODE = 8'b0000_0110;
	localparam logic [BYTE_W-1:0] INSTR_DISP_ON    = 8'b0000_1100;
	localparam logic [BYTE_W-1:0] INSTR_SET_DDRAM  = 8'b1000_0000;
	localparam logic [BYTE_W-1:0] INSTR_CURSOR_RT  = 8'b0001_0100;
	localparam logic [BYTE_W-1:0] NIB_WAKE         = 8'h03;
	localparam logic [BYTE_W-1:0] NIB_4BIT         = 8'h02;
	localparam logic [BYTE_W-1:0] BYTE_NONE        = 8'h00;

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_INSTR  = 3'd1,
		OP_DATA   = 3'd2,
		OP_GOTO   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_ONOFF  = 3'd5,
		OP_RIGHT  = 3'd6
	} op_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef enum logic [1:0] {
		NIB_CONST,
		NIB_HI,
		NIB_LO
	} nib_sel_t;

	typedef enum logic [2:0] {
		WAIT_ZERO,
		WAIT_CMD,
		WAIT_1MS,
		WAIT_10MS,
		WAIT_50MS
	} wait_sel_t;

	// One control word of the program.
	typedef struct packed {
		logic              strobe;     // pulse enable, else wait only
		nib_sel_t          nib_sel;
		logic              use_const;  // byte source: constant, else command byte
		logic [BYTE_W-1:0] const_byte;
		wait_sel_t         wait_sel;
		logic              last;       // final word of the command
		logic              done;       // return to idle after this step
		logic              br_extra;   // continue only if the extra wait is requested
	} uop_t;

	// What the sequencer hands to the datapath each cycle.
	typedef struct packed {
		logic valid;
		logic last;
		uop_t uop;
	} step_t;

	localparam logic [PC_W-1:0] ENTRY_INIT = 5'd0;
	localparam logic [PC_W-1:0] ENTRY_CMD  = 5'd15;

	function automatic uop_t mk(input logic strobe, input nib_sel_t ns, input logic uc,
			input logic [BYTE_W-1:0] cb, input wait_sel_t ws, input logic lst,
			input logic dn, input logic br);
		uop_t u;
		u.strobe     = strobe;
		u.nib_sel    = ns;
		u.use_const  = uc;
		u.const_byte = cb;
		u.wait_sel   = ws;
		u.last       = lst;
		u.done       = dn;
		u.br_extra   = br;
		return u;
	endfunction

	// The microcode program. Steps 0 to 14 are the power-up init, steps 15
	// to 17 send the command byte and the optional trailing wait.
	function automatic uop_t ucode_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = mk(1'b0, NIB_CONST, 1'b1, BYTE_NONE, WAIT_50MS, 1'b0, 1'b0, 1'b0);
			5'd1:  u = mk(1'b1, NIB_CONST, 1'b1, NIB_WAKE, WAIT_10MS, 1'b0, 1'b0, 1'b0);
			5'd2:  u = mk(1'b1, NIB_CONST, 1'b1, NIB_WAKE, WAIT_10MS, 1'b0, 1'b0, 1'b0);
			5'd3:  u = mk(1'b1, NIB_CONST, 1'b1, NIB_WAKE, WAIT_10MS, 1'b0, 1'b0, 1'b0);
			5'd4:  u = mk(1'b1, NIB_CONST, 1'b1, NIB_4BIT, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd5:  u = mk(1'b1, NIB_HI, 1'b1, INSTR_FUNC_SET, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd6:  u = mk(1'b1, NIB_LO, 1'b1, INSTR_FUNC_SET, WAIT_CMD, 1'b0, 1'b0, 1'b0);
			5'd7:  u = mk(1'b1, NIB_HI, 1'b1, INSTR_DISP_OFF, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd8:  u = mk(1'b1, NIB_LO, 1'b1, INSTR_DISP_OFF, WAIT_CMD, 1'b0, 1'b0, 1'b0);
			5'd9:  u = mk(1'b1, NIB_HI, 1'b1, INSTR_CLEAR, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd10: u = mk(1'b1, NIB_LO, 1'b1, INSTR_CLEAR, WAIT_CMD, 1'b0, 1'b0, 1'b0);
			5'd11: u = mk(1'b1, NIB_HI, 1'b1, INSTR_ENTRY_MODE, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd12: u = mk(1'b1, NIB_LO, 1'b1, INSTR_ENTRY_MODE, WAIT_CMD, 1'b0, 1'b0, 1'b0);
			5'd13: u = mk(1'b1, NIB_HI, 1'b1, INSTR_DISP_ON, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd14: u = mk(1'b1, NIB_LO, 1'b1, INSTR_DISP_ON, WAIT_CMD, 1'b1, 1'b1, 1'b0);
			5'd15: u = mk(1'b1, NIB_HI, 1'b0, BYTE_NONE, WAIT_ZERO, 1'b0, 1'b0, 1'b0);
			5'd16: u = mk(1'b1, NIB_LO, 1'b0, BYTE_NONE, WAIT_CMD, 1'b0, 1'b0, 1'b1);
			5'd17: u = mk(1'b0, NIB_CONST, 1'b1, BYTE_NONE, WAIT_1MS, 1'b1, 1'b1, 1'b0);
			default: u = mk(1'b0, NIB_CONST, 1'b1, BYTE_NONE, WAIT_ZERO, 1'b0, 1'b1, 1'b0);
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

>>> design/lcdseq_ctrl.sv
// Microcode sequencer: step counter, program fetch and branch logic.
// Depends on lcdseq_pkg.
`default_nettype none

module lcdseq_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic [lcdseq_pkg::PC_W-1:0] entry,
	input  wire logic                    extra,
	output lcdseq_pkg::step_t            step,
	output logic                         busy
);
	import lcdseq_pkg::*;

	seq_state_t          state_q, state_d;
	logic [PC_W-1:0]     pc_q, pc_d;
	uop_t                uop;
	logic                stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		uop     = ucode_rom(pc_q);
		// The conditional branch ends the command after the low nibble when
		// no trailing wait is requested.
		stop    = uop.done | (uop.br_extra & ~extra);
		state_d = state_q;
		pc_d    = pc_q;
		step.valid = 1'b0;
		step.last  = 1'b0;
		step.uop   = uop;
		case (state_q)
			SEQ_IDLE: begin
				if (go) begin
					state_d = SEQ_RUN;
					pc_d    = entry;
				end
			end
			SEQ_RUN: begin
				step.valid = 1'b1;
				step.last  = uop.last | (uop.br_extra & ~extra);
				if (stop) begin
					state_d = SEQ_IDLE;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	assign busy = (state_q != SEQ_IDLE);

endmodule

`default_nettype wire

>>> design/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD nibble write sequencer.
// Command decode, operand registers and output datapath; uses lcdseq_pkg and lcdseq_ctrl.
// A start is registered in the sequencer state; words then pass the output register.
// Throughput: one word per cycle; a command keeps busy high while its words are issued.
// Init gives 15 words; a new command is taken only while busy is low.
// The receiver cannot stall; strobe marks each word for exactly one cycle.
// Reset clears the sequencer, the output strobe and sets instr_wait_q to 1000.
`default_nettype none

module char_lcd_nibble_write_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  value,
	input  wire logic [4:0]  col,
	input  wire logic [1:0]  row,
	input  wire logic        cursor_on,
	input  wire logic        blink_on,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             strobe,
	output logic             strobe_res,
	output logic             reg_select,
	output logic [3:0]       nibble,
	output logic [15:0]      wait_after_us,
	output logic             last
);
	import lcdseq_pkg::*;

	// Configuration register: wait after the low nibble of an instruction.
	logic [WAIT_W-1:0] instr_wait_q;

	// Operands latched when a command is accepted.
	logic [BYTE_W-1:0] byte_q;
	logic              rs_q;
	logic              extra_q;

	// Decode of the incoming command.
	logic [BYTE_W-1:0] cmd_byte;
	logic              cmd_rs;
	logic              cmd_extra;
	logic              cmd_ok;
	logic              cmd_init;
	logic              accept;

	step_t             step;
	logic [BYTE_W-1:0] src_byte;
	logic              eff_rs;
	logic [NIBBLE_W-1:0] nib_d;
	logic [WAIT_W-1:0] wait_d;

	always_comb begin
		cmd_byte  = value;
		cmd_rs    = 1'b0;
		cmd_extra = 1'b0;
		cmd_ok    = 1'b1;
		cmd_init  = 1'b0;
		case (op_t'(opcode))
			OP_INIT: begin
				cmd_init = 1'b1;
			end
			OP_INSTR: begin
				cmd_byte = value;
			end
			OP_DATA: begin
				cmd_byte = value;
				cmd_rs   = 1'b1;
			end
			OP_GOTO: begin
				// Line two starts at address 0x40; rows above one and
				// columns above fifteen are dropped without output.
				cmd_byte = INSTR_SET_DDRAM | {1'b0, row[0], 2'b00, col[3:0]};
				cmd_ok   = ~row[1] & ~col[4];
			end
			OP_CLEAR: begin
				cmd_byte  = INSTR_CLEAR;
				cmd_extra = 1'b1;
			end
			OP_ONOFF: begin
				cmd_byte  = INSTR_DISP_OFF | {5'b00000, cursor_on, blink_on, 1'b0};
				cmd_extra = 1'b1;
			end
			OP_RIGHT: begin
				cmd_byte = INSTR_CURSOR_RT;
			end
			default: begin
				// The unused opcode is taken and ignored.
				cmd_ok = 1'b0;
			end
		endcase
	end

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_wait_q <= INSTR_WAIT_RESET;
		end else if (cfg_we) begin
			instr_wait_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q  <= cmd_byte;
			rs_q    <= cmd_rs;
			extra_q <= cmd_extra;
		end
	end

	lcdseq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept & cmd_ok),
		.entry  (cmd_init ? ENTRY_INIT : ENTRY_CMD),
		.extra  (extra_q),
		.step   (step),
		.busy   (busy)
	);

	// Datapath driven by the current control word. Constant bytes from the
	// program always go to the instruction register; the command byte uses
	// the register select latched with the command.
	always_comb begin
		src_byte = step.uop.use_const ? step.uop.const_byte : byte_q;
		eff_rs   = step.uop.use_const ? 1'b0 : rs_q;
		case (step.uop.nib_sel)
			NIB_HI:    nib_d = src_byte[7:4];
			NIB_LO:    nib_d = src_byte[3:0];
			default:   nib_d = step.uop.const_byte[3:0];
		endcase
		case (step.uop.wait_sel)
			WAIT_CMD:  wait_d = eff_rs ? '0 : instr_wait_q;
			WAIT_1MS:  wait_d = WAIT_1MS_US;
			WAIT_10MS: wait_d = WAIT_10MS_US;
			WAIT_50MS: wait_d = WAIT_50MS_US;
			default:   wait_d = '0;
		endcase
	end

	// Output word register: one word per cycle, shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid) begin
			strobe_res    <= step.uop.strobe;
			reg_select    <= eff_rs;
			nibble        <= nib_d;
			wait_after_us <= wait_d;
			last          <= step.last;
		end
	end

endmodule

`default_nettype wire
